// File: rtl/core/assert_macros.svh
// Assertion macros for the checker files of the RTL folder.
// No dependencies; each checker that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

// File: rtl/core/pifd_pkg.sv
// Types and constants for the pulse interval frame decoder.
// No dependencies; imported by the decoder top level.
package pifd_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_START    = 2'd1,
        MODE_ORIGINAL = 2'd2,
        MODE_VERIFY   = 2'd3
    } mode_t;

    localparam int TICK_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int LIMIT_W = 8;
    localparam int COUNT_W = 5;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 3;

    typedef enum logic [CIDX_W-1:0] {
        CFG_START_MIN     = 3'd0,
        CFG_START_MAX     = 3'd1,
        CFG_ZERO_MIN      = 3'd2,
        CFG_ONE_THRESHOLD = 3'd3,
        CFG_ONE_MAX       = 3'd4,
        CFG_ERROR_LIMIT   = 3'd5
    } cfg_index_t;

    localparam logic [TICK_W-1:0]  RST_START_MIN     = 16'd875;
    localparam logic [TICK_W-1:0]  RST_START_MAX     = 16'd1625;
    localparam logic [TICK_W-1:0]  RST_ZERO_MIN      = 16'd150;
    localparam logic [TICK_W-1:0]  RST_ONE_THRESHOLD = 16'd325;
    localparam logic [TICK_W-1:0]  RST_ONE_MAX       = 16'd588;
    localparam logic [LIMIT_W-1:0] RST_ERROR_LIMIT   = 8'd60;

    localparam logic [COUNT_W-1:0] BITS_ORIGINAL = 5'd8;
    localparam logic [COUNT_W-1:0] BITS_FRAME    = 5'd16;

    typedef struct packed {
        logic              byte_valid;
        logic [BYTE_W-1:0] data_byte;
        logic              frame_abort;
    } result_t;

endpackage

// File: rtl/core/pulse_interval_frame_decoder.sv
// Pulse interval frame decoder: decodes a complement-checked byte from edge intervals.
// Depends on pifd_pkg for the mode, register index and result types.
//
// Usage: each input transaction (in_valid/in_ready) carries one falling edge,
// req_type (1 for the arming pin, 0 for the data pin) and interval_ticks, the
// timer ticks since the previous edge. Every input transaction produces
// exactly one output transaction (out_valid/out_ready) with byte_valid,
// data_byte and frame_abort. Registers are written through cfg_we, cfg_index
// and cfg_wdata; the user must write them only while the decoder is idle,
// which the block itself does not enforce. Results are registered into the
// one-entry output register, or into the skid register while the receiver stalls.
// Throughput is one transaction per cycle while the skid register is empty,
// set by the single registered state update per edge. While the one-entry
// skid register holds a result, in_ready stays low until it drains.
// Reset clears the decoder to idle, the error counter to zero, the
// registers to their default windows and empties both result registers.
module pulse_interval_frame_decoder
    import pifd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                req_type,
    input  logic [TICK_W-1:0]   interval_ticks,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                byte_valid,
    output logic [BYTE_W-1:0]   data_byte,
    output logic                frame_abort
);

    logic [TICK_W-1:0]  start_min_reg;
    logic [TICK_W-1:0]  start_max_reg;
    logic [TICK_W-1:0]  zero_min_reg;
    logic [TICK_W-1:0]  one_threshold_reg;
    logic [TICK_W-1:0]  one_max_reg;
    logic [LIMIT_W-1:0] error_limit_reg;

    mode_t              mode_reg, mode_next;
    logic [COUNT_W-1:0] bit_count_reg, bit_count_next;
    logic [BYTE_W-1:0]  original_reg, original_next;
    logic [BYTE_W-1:0]  verify_reg, verify_next;
    logic [LIMIT_W-1:0] error_count_reg, error_count_next;

    result_t            result;
    result_t            out_reg;
    result_t            skid_reg;
    logic               out_valid_reg;
    logic               skid_valid_reg;

    logic               accept;
    logic               in_start_window;
    logic               is_zero;
    logic               is_one;
    logic               bit_ok;
    logic [COUNT_W-1:0] bit_count_inc;
    logic [BYTE_W-1:0]  original_shifted;
    logic [BYTE_W-1:0]  verify_shifted;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;

    assign in_start_window = (interval_ticks >= start_min_reg)
                          && (interval_ticks <= start_max_reg);
    assign is_zero = (interval_ticks > zero_min_reg)
                  && (interval_ticks <= one_threshold_reg);
    assign is_one  = (interval_ticks > one_threshold_reg)
                  && (interval_ticks < one_max_reg);
    assign bit_ok  = is_zero || is_one;

    assign bit_count_inc    = bit_count_reg + COUNT_W'(1);
    assign original_shifted = {original_reg[BYTE_W-2:0], !is_zero};
    assign verify_shifted   = {verify_reg[BYTE_W-2:0], !is_zero};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_min_reg     <= RST_START_MIN;
            start_max_reg     <= RST_START_MAX;
            zero_min_reg      <= RST_ZERO_MIN;
            one_threshold_reg <= RST_ONE_THRESHOLD;
            one_max_reg       <= RST_ONE_MAX;
            error_limit_reg   <= RST_ERROR_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_MIN:     start_min_reg     <= cfg_wdata;
                CFG_START_MAX:     start_max_reg     <= cfg_wdata;
                CFG_ZERO_MIN:      zero_min_reg      <= cfg_wdata;
                CFG_ONE_THRESHOLD: one_threshold_reg <= cfg_wdata;
                CFG_ONE_MAX:       one_max_reg       <= cfg_wdata;
                CFG_ERROR_LIMIT:   error_limit_reg   <= cfg_wdata[LIMIT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Next state of the decoder for the current edge.
    always_comb
    begin
        mode_next        = mode_reg;
        bit_count_next   = bit_count_reg;
        original_next    = original_reg;
        verify_next      = verify_reg;
        error_count_next = error_count_reg;
        if (req_type)
        begin
            mode_next = (mode_reg == MODE_IDLE) ? MODE_START : MODE_IDLE;
        end
        else
        begin
            case (mode_reg)
                MODE_START:
                begin
                    if (in_start_window)
                    begin
                        mode_next      = MODE_ORIGINAL;
                        bit_count_next = '0;
                        original_next  = '0;
                        verify_next    = '0;
                    end
                    else if (error_count_reg < error_limit_reg)
                    begin
                        error_count_next = error_count_reg + LIMIT_W'(1);
                    end
                    else
                    begin
                        error_count_next = '0;
                        mode_next        = MODE_IDLE;
                    end
                end
                MODE_ORIGINAL:
                begin
                    if (!bit_ok)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        bit_count_next = bit_count_inc;
                        original_next  = original_shifted;
                        if (bit_count_inc == BITS_ORIGINAL)
                        begin
                            mode_next = MODE_VERIFY;
                        end
                    end
                end
                MODE_VERIFY:
                begin
                    if (!bit_ok)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        bit_count_next = bit_count_inc;
                        verify_next    = verify_shifted;
                        if (bit_count_inc == BITS_FRAME)
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end
    end

    // Result fields for the current edge.
    always_comb
    begin
        result = '0;
        if (req_type)
        begin
            result.frame_abort = (mode_reg != MODE_IDLE);
        end
        else
        begin
            case (mode_reg)
                MODE_START:
                begin
                    result.frame_abort = !in_start_window
                                      && !(error_count_reg < error_limit_reg);
                end
                MODE_ORIGINAL:
                begin
                    result.frame_abort = !bit_ok;
                end
                MODE_VERIFY:
                begin
                    if (!bit_ok)
                    begin
                        result.frame_abort = 1'b1;
                    end
                    else if (bit_count_inc == BITS_FRAME)
                    begin
                        if (verify_shifted == ~original_reg)
                        begin
                            result.byte_valid = 1'b1;
                            result.data_byte  = original_reg;
                        end
                        else
                        begin
                            result.frame_abort = 1'b1;
                        end
                    end
                end
                default:
                begin
                    result = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            bit_count_reg   <= '0;
            original_reg    <= '0;
            verify_reg      <= '0;
            error_count_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg        <= mode_next;
            bit_count_reg   <= bit_count_next;
            original_reg    <= original_next;
            verify_reg      <= verify_next;
            error_count_reg <= error_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_ready)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (accept)
            begin
                if (out_valid_reg && !out_ready)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign byte_valid  = out_reg.byte_valid;
    assign data_byte   = out_reg.data_byte;
    assign frame_abort = out_reg.frame_abort;

endmodule

// File: rtl/core/pifd_checker.sv
// Port-level checker for the pulse interval frame decoder, bound to the top level.
// Depends on assert_macros.svh for the assertion macros.
`include "assert_macros.svh"

module pifd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       byte_valid,
    input logic [7:0] data_byte,
    input logic       frame_abort
);

    `ASSERT_CLK(a_result_after_accept, in_valid && in_ready |=> out_valid)
    `ASSERT_CLK(a_valid_xor_abort, out_valid |-> !(byte_valid && frame_abort))
    `ASSERT_CLK(a_data_zero_unless_valid, out_valid && !byte_valid |-> data_byte == 8'd0)
    `ASSERT_CLK(a_stall_holds, out_valid && !out_ready |=> out_valid && $stable(data_byte))
    `ASSERT_ALWAYS(a_no_output_in_reset, !rst_n |=> !out_valid || !rst_n || $past(!rst_n))

endmodule

bind pulse_interval_frame_decoder pifd_checker u_pifd_checker (.*);
